>>> hw/rtl/cphd_pkg.sv
// Shared types and constants for the coil pulse-and-hold driver channel.
// Depends on nothing; imported by the top level.
`default_nettype none

package cphd_pkg;

  // Number of end-of-travel stop inputs handled by the channel (1 or 2).
  localparam int unsigned STOP_INPUTS = 2;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 8;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_HOST       = 3'd1,
    CMD_SWITCH     = 3'd2,
    CMD_TILT       = 3'd3,
    CMD_POWER_LOST = 3'd4
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRIVE_POWER   = 8'd0,
    REG_HOLD_POWER    = 8'd1,
    REG_MIN_PULSE_MS  = 8'd2,
    REG_MAX_PULSE_MS  = 8'd3,
    REG_HOLD_DELAY_MS = 8'd4,
    REG_DRIVE_SWITCH  = 8'd5,
    REG_STOP_SWITCH_A = 8'd6,
    REG_STOP_SWITCH_B = 8'd7
  } reg_index_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now_ms;
    logic [7:0]  switch_id;
    logic        level;
    logic        power_ok;
    logic        tilt_active;
    logic        fire_allowed;
    logic        drive_switch_closed;
    logic        stop_a_closed;
    logic        stop_b_closed;
  } cphd_in_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       is_active;
    logic       is_stopped;
    logic       awaiting_release;
  } cphd_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/coil_pulse_hold_driver_unit.sv
// Top level of the coil pulse-and-hold driver: configuration registers,
// channel state, next-state logic and the result register. Uses cphd_pkg.
`default_nettype none

// One coil or motor output channel. Each accepted request (tick, host command,
// switch edge, tilt latch or power loss) updates the channel state and yields
// one result: the PWM duty now applied and the active, stopped and
// awaiting-release flags. The whole update is one level of compare-and-select
// logic between the state registers and a single result register, so a request
// is accepted every clock cycle and its result appears in the next cycle.
// in_ready is high whenever the result register is empty or is being taken in
// the same cycle, so the channel only stalls when the consumer holds off.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect for the next request; writes to unknown indexes are ignored.
module coil_pulse_hold_driver_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [cphd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [cphd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire cphd_pkg::cphd_in_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cphd_pkg::cphd_out_t                      out_data
);
  import cphd_pkg::*;

  typedef struct packed {
    logic                   active;
    logic [31:0]            start_time;
    logic [7:0]             duty_now;
    logic                   off_pending;
    logic                   drive_seen_closed;
    logic                   switch_managed;
    logic                   wait_release;
    logic [STOP_INPUTS-1:0] stop_seen_closed;
    logic                   stop_engaged;
  } chan_state_t;

  // Configuration registers.
  logic [7:0]  drive_power;
  logic [7:0]  hold_power;
  logic [15:0] min_pulse_ms;
  logic [15:0] max_pulse_ms;
  logic [15:0] hold_delay_ms;
  logic [7:0]  drive_switch;
  logic [7:0]  stop_switch_a;
  logic [7:0]  stop_switch_b;

  chan_state_t state;
  chan_state_t state_next;
  logic        accept;

  logic [7:0]  stop_cfg [0:1];
  logic [1:0]  stop_level;

  assign stop_cfg[0] = stop_switch_a;
  assign stop_cfg[1] = stop_switch_b;
  assign stop_level  = {in_data.stop_b_closed, in_data.stop_a_closed};

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  function automatic chan_state_t cut(input chan_state_t s);
    chan_state_t r;
    r                = s;
    r.active         = 1'b0;
    r.start_time     = '0;
    r.duty_now       = '0;
    r.off_pending    = 1'b0;
    r.switch_managed = 1'b0;
    return r;
  endfunction

  function automatic chan_state_t fire(input chan_state_t s, input logic [31:0] now,
                                       input logic managed, input logic [7:0] power);
    chan_state_t r;
    r                = s;
    r.active         = 1'b1;
    r.start_time     = now;
    r.duty_now       = power;
    r.off_pending    = 1'b0;
    r.switch_managed = managed;
    return r;
  endfunction

  always_comb begin
    chan_state_t s;
    logic [31:0] el;
    logic        min_done;
    logic        any_closed;
    logic        rising;
    logic        stops_cfgd;

    s          = state;
    el         = '0;
    min_done   = 1'b0;
    any_closed = 1'b0;
    rising     = 1'b0;
    stops_cfgd = 1'b0;

    case (in_data.cmd)
      CMD_TICK: begin
        for (int i = 0; i < STOP_INPUTS; i++) begin
          if (stop_cfg[i] != '0) begin
            stops_cfgd = 1'b1;
          end
        end
        if (stops_cfgd) begin
          for (int i = 0; i < STOP_INPUTS; i++) begin
            if (stop_cfg[i] != '0) begin
              if (stop_level[i] && !s.stop_seen_closed[i] && s.active) begin
                s.stop_engaged = 1'b1;
                s = cut(s);
              end
              s.stop_seen_closed[i] = stop_level[i];
            end
          end
          for (int i = 0; i < STOP_INPUTS; i++) begin
            if (stop_cfg[i] != '0 && s.stop_seen_closed[i]) begin
              any_closed = 1'b1;
            end
          end
          if (s.stop_engaged && !any_closed) begin
            s.stop_engaged = 1'b0;
          end
        end

        if (drive_switch != '0) begin
          if (in_data.fire_allowed) begin
            s.drive_seen_closed = in_data.drive_switch_closed;
            if (!in_data.drive_switch_closed) begin
              s.wait_release = 1'b0;
            end
          end else begin
            s.drive_seen_closed = 1'b0;
            s.wait_release      = 1'b1;
          end
        end

        if (in_data.fire_allowed && !s.active && !s.stop_engaged && drive_switch != '0 &&
            s.drive_seen_closed && !s.wait_release) begin
          s = fire(s, in_data.now_ms, 1'b1, drive_power);
        end

        if (s.active) begin
          el       = in_data.now_ms - s.start_time;
          min_done = (min_pulse_ms == '0) || (el > {16'd0, min_pulse_ms});
          if (max_pulse_ms != '0 && el > {16'd0, max_pulse_ms}) begin
            if (s.switch_managed && s.drive_seen_closed) begin
              s.wait_release = 1'b1;
            end
            s = cut(s);
          end else if (s.off_pending && min_done) begin
            s = cut(s);
          end else if (s.switch_managed && min_done && !s.drive_seen_closed) begin
            s = cut(s);
          end else if (hold_delay_ms != '0 && s.duty_now > hold_power &&
                       el > {16'd0, hold_delay_ms}) begin
            s.duty_now = hold_power;
          end
        end
      end

      CMD_HOST: begin
        if (in_data.power_ok) begin
          if (in_data.level && s.stop_engaged) begin
            s = s;
          end else if (in_data.level && !s.active) begin
            s = fire(s, in_data.now_ms, 1'b0, drive_power);
          end else if (!in_data.level && s.active) begin
            el = in_data.now_ms - s.start_time;
            if (min_pulse_ms != '0 && el < {16'd0, min_pulse_ms}) begin
              s.off_pending = 1'b1;
            end else begin
              s = cut(s);
            end
          end
        end
      end

      CMD_SWITCH: begin
        if (in_data.power_ok) begin
          for (int i = 0; i < STOP_INPUTS; i++) begin
            if (stop_cfg[i] != '0 && stop_cfg[i] == in_data.switch_id) begin
              if (in_data.level && !s.stop_seen_closed[i]) begin
                rising = 1'b1;
              end
              s.stop_seen_closed[i] = in_data.level;
            end
          end
          if (rising && s.active) begin
            s.stop_engaged = 1'b1;
            s = cut(s);
          end else begin
            for (int i = 0; i < STOP_INPUTS; i++) begin
              if (stop_cfg[i] != '0 && s.stop_seen_closed[i]) begin
                any_closed = 1'b1;
              end
            end
            if (s.stop_engaged && !any_closed) begin
              s.stop_engaged = 1'b0;
            end
          end

          if (!in_data.tilt_active && drive_switch != '0 &&
              drive_switch == in_data.switch_id) begin
            s.drive_seen_closed = in_data.level;
            if (!in_data.level) begin
              s.wait_release = 1'b0;
              el = in_data.now_ms - s.start_time;
              // An opening edge ends a switch-driven pulse once the minimum is over.
              if (s.active && s.switch_managed &&
                  !(min_pulse_ms != '0 && el <= {16'd0, min_pulse_ms})) begin
                s = cut(s);
              end
            end else if (!s.wait_release && !s.stop_engaged && !s.active) begin
              s = fire(s, in_data.now_ms, 1'b1, drive_power);
            end
          end
        end
      end

      CMD_TILT: begin
        if (in_data.tilt_active && drive_switch != '0) begin
          s                   = cut(s);
          s.drive_seen_closed = 1'b0;
          s.wait_release      = 1'b1;
        end
      end

      CMD_POWER_LOST: begin
        if (!in_data.power_ok) begin
          s                   = cut(s);
          s.wait_release      = 1'b0;
          s.drive_seen_closed = 1'b0;
        end
      end

      default: begin
        s = state;
      end
    endcase

    state_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_power   <= '0;
      hold_power    <= '0;
      min_pulse_ms  <= '0;
      max_pulse_ms  <= '0;
      hold_delay_ms <= '0;
      drive_switch  <= '0;
      stop_switch_a <= '0;
      stop_switch_b <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE_POWER:   drive_power   <= cfg_data[7:0];
        REG_HOLD_POWER:    hold_power    <= cfg_data[7:0];
        REG_MIN_PULSE_MS:  min_pulse_ms  <= cfg_data[15:0];
        REG_MAX_PULSE_MS:  max_pulse_ms  <= cfg_data[15:0];
        REG_HOLD_DELAY_MS: hold_delay_ms <= cfg_data[15:0];
        REG_DRIVE_SWITCH:  drive_switch  <= cfg_data[7:0];
        REG_STOP_SWITCH_A: stop_switch_a <= cfg_data[7:0];
        REG_STOP_SWITCH_B: stop_switch_b <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.pwm_duty         <= state_next.duty_now;
      out_data.is_active        <= state_next.active;
      out_data.is_stopped       <= state_next.stop_engaged;
      out_data.awaiting_release <= state_next.wait_release;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_coil_pulse_hold_driver_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for coil_pulse_hold_driver_unit: directed and random
// requests under several register settings, each result checked against a
// behavioral prediction of the channel. Depends on cphd_pkg and the unit RTL.

module tb_coil_pulse_hold_driver_unit;
  import cphd_pkg::*;

  localparam int N_STOPS = (STOP_INPUTS < 2) ? 1 : 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam bit [CFG_INDEX_W-1:0] REG_UNUSED_NEXT = CFG_INDEX_W'(REG_STOP_SWITCH_B + 1);
  localparam bit [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;
  localparam int CMD_UNUSED_FIRST = CMD_POWER_LOST + 1;
  localparam int CMD_CODES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cphd_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cphd_out_t out_data;

  coil_pulse_hold_driver_unit u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Register copies as the channel should hold them.
  bit [7:0] drive_pw, hold_pw, drive_sw_id, stop_a_id, stop_b_id;
  bit [15:0] min_on_ms, max_on_ms, hold_after_ms;

  // Predicted channel state.
  bit coil_on, off_req, drive_held, fired_by_switch, need_release, stopped;
  bit [31:0] on_since;
  bit [7:0] duty;
  bit stop_seen[2];

  cphd_in_t request_q[$];
  cphd_out_t status_due[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit idling_on = 1'b1;

  // Stimulus-side view of the switch levels and the millisecond clock.
  bit [31:0] sim_now = 32'd10000;
  bit lv_drive, lv_stop_a, lv_stop_b;

  function automatic bit [7:0] stop_id(int s);
    return (s == 0) ? stop_a_id : stop_b_id;
  endfunction

  function automatic void coil_cut();
    coil_on = 1'b0;
    on_since = '0;
    duty = '0;
    off_req = 1'b0;
    fired_by_switch = 1'b0;
  endfunction

  function automatic void coil_fire(bit [31:0] t, bit by_switch);
    coil_on = 1'b1;
    on_since = t;
    duty = drive_pw;
    off_req = 1'b0;
    fired_by_switch = by_switch;
  endfunction

  function automatic bit any_stop_down();
    for (int s = 0; s < N_STOPS; s++)
      if (stop_id(s) != 0 && stop_seen[s]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void try_release();
    if (stopped && !any_stop_down()) stopped = 1'b0;
  endfunction

  function automatic void coil_tick(cphd_in_t r);
    bit closed, min_done;
    bit [31:0] el;
    if (stop_a_id != 0 || (N_STOPS > 1 && stop_b_id != 0)) begin
      for (int s = 0; s < N_STOPS; s++) begin
        if (stop_id(s) != 0) begin
          closed = (s == 0) ? r.stop_a_closed : r.stop_b_closed;
          if (closed && !stop_seen[s] && coil_on) begin
            stopped = 1'b1;
            coil_cut();
          end
          stop_seen[s] = closed;
        end
      end
      try_release();
    end
    if (drive_sw_id != 0) begin
      if (r.fire_allowed) begin
        drive_held = r.drive_switch_closed;
        if (!drive_held) need_release = 1'b0;
      end else begin
        drive_held = 1'b0;
        need_release = 1'b1;
      end
    end
    if (r.fire_allowed && !coil_on && !stopped && drive_sw_id != 0 && drive_held &&
        !need_release)
      coil_fire(r.now_ms, 1'b1);
    if (coil_on) begin
      el = r.now_ms - on_since;
      min_done = (min_on_ms == 0) || (el > 32'(min_on_ms));
      if (max_on_ms != 0 && el > 32'(max_on_ms)) begin
        if (fired_by_switch && drive_held) need_release = 1'b1;
        coil_cut();
      end else if (off_req && min_done) begin
        coil_cut();
      end else if (fired_by_switch && min_done && !drive_held) begin
        coil_cut();
      end else if (hold_after_ms != 0 && duty > hold_pw && el > 32'(hold_after_ms)) begin
        duty = hold_pw;
      end
    end
  endfunction

  function automatic void coil_host(bit on, bit [31:0] t);
    bit [31:0] el;
    el = t - on_since;
    if (on && stopped) return;
    if (on && !coil_on) begin
      coil_fire(t, 1'b0);
    end else if (!on && coil_on) begin
      if (min_on_ms != 0 && el < 32'(min_on_ms)) off_req = 1'b1;
      else coil_cut();
    end
  endfunction

  function automatic void drive_edge(bit closed, bit [31:0] t);
    bit [31:0] el;
    el = t - on_since;
    drive_held = closed;
    if (!closed) begin
      need_release = 1'b0;
      if (coil_on && fired_by_switch && !(min_on_ms != 0 && el <= 32'(min_on_ms)))
        coil_cut();
    end else if (!need_release && !stopped && !coil_on) begin
      coil_fire(t, 1'b1);
    end
  endfunction

  function automatic void coil_edge(cphd_in_t r);
    bit rising;
    rising = 1'b0;
    for (int s = 0; s < N_STOPS; s++) begin
      if (stop_id(s) != 0 && stop_id(s) == r.switch_id) begin
        if (r.level && !stop_seen[s]) rising = 1'b1;
        stop_seen[s] = r.level;
      end
    end
    if (rising && coil_on) begin
      stopped = 1'b1;
      coil_cut();
    end else begin
      try_release();
    end
    if (!r.tilt_active && drive_sw_id != 0 && drive_sw_id == r.switch_id)
      drive_edge(r.level, r.now_ms);
  endfunction

  // Applies one request to the predicted state and returns the status it yields.
  function automatic cphd_out_t coil_next_status(cphd_in_t r);
    cphd_out_t s;
    case (r.cmd)
      CMD_TICK: coil_tick(r);
      CMD_HOST: if (r.power_ok) coil_host(r.level, r.now_ms);
      CMD_SWITCH: if (r.power_ok) coil_edge(r);
      CMD_TILT: begin
        if (r.tilt_active && drive_sw_id != 0) begin
          coil_cut();
          drive_held = 1'b0;
          need_release = 1'b1;
        end
      end
      CMD_POWER_LOST: begin
        if (!r.power_ok) begin
          coil_cut();
          need_release = 1'b0;
          drive_held = 1'b0;
        end
      end
      default: ;
    endcase
    s.pwm_duty = duty;
    s.is_active = coil_on;
    s.is_stopped = stopped;
    s.awaiting_release = need_release;
    return s;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (idling_on && request_q.size() != 0 && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 7);
      end else if (request_q.size() != 0) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result consumer stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Prediction on each accepted request, checking on each accepted result.
  always @(posedge clk) begin
    cphd_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) status_due.push_back(coil_next_status(in_data));
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          note_failure($sformatf("result %p with no request pending", out_data));
        end else begin
          want = status_due.pop_front();
          if (out_data.pwm_duty !== want.pwm_duty)
            note_failure($sformatf("pwm_duty expected %0d, got %0d",
                                   want.pwm_duty, out_data.pwm_duty));
          if (out_data.is_active !== want.is_active)
            note_failure($sformatf("is_active expected %0b, got %0b",
                                   want.is_active, out_data.is_active));
          if (out_data.is_stopped !== want.is_stopped)
            note_failure($sformatf("is_stopped expected %0b, got %0b",
                                   want.is_stopped, out_data.is_stopped));
          if (out_data.awaiting_release !== want.awaiting_release)
            note_failure($sformatf("awaiting_release expected %0b, got %0b",
                                   want.awaiting_release, out_data.awaiting_release));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", status_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic cphd_in_t req(bit [2:0] c, bit [31:0] t, bit [7:0] id, bit lvl);
    cphd_in_t r;
    r = '0;
    r.cmd = c;
    r.now_ms = t;
    r.switch_id = id;
    r.level = lvl;
    r.power_ok = 1'b1;
    r.fire_allowed = 1'b1;
    return r;
  endfunction

  // Mostly well-formed traffic: edges follow the switch levels that ticks report,
  // and time advances in steps scaled to the configured pulse times.
  function automatic cphd_in_t random_request();
    cphd_in_t r;
    int unsigned pick, longest;
    longest = 32'(min_on_ms);
    if (32'(max_on_ms) > longest) longest = 32'(max_on_ms);
    if (32'(hold_after_ms) > longest) longest = 32'(hold_after_ms);
    sim_now += $urandom_range(0, longest / 6 + 3);
    if ($urandom_range(0, 63) == 0) sim_now = $urandom();
    r = '0;
    r.now_ms = sim_now;
    r.power_ok = ($urandom_range(0, 19) != 0);
    r.tilt_active = ($urandom_range(0, 15) == 0);
    r.fire_allowed = ($urandom_range(0, 9) != 0);
    r.level = 1'($urandom_range(0, 1));
    r.switch_id = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.cmd = CMD_TICK;
      if ($urandom_range(0, 5) == 0) lv_drive = !lv_drive;
      if ($urandom_range(0, 5) == 0) lv_stop_a = !lv_stop_a;
      if ($urandom_range(0, 5) == 0) lv_stop_b = !lv_stop_b;
      r.drive_switch_closed = lv_drive;
      r.stop_a_closed = lv_stop_a;
      r.stop_b_closed = lv_stop_b;
    end else if (pick < 65) begin
      r.cmd = CMD_HOST;
    end else if (pick < 90) begin
      r.cmd = CMD_SWITCH;
      case ($urandom_range(0, 3))
        0: begin
          if ($urandom_range(0, 4) != 0) lv_drive = !lv_drive;
          r.switch_id = drive_sw_id;
          r.level = lv_drive;
        end
        1: begin
          if ($urandom_range(0, 4) != 0) lv_stop_a = !lv_stop_a;
          r.switch_id = stop_a_id;
          r.level = lv_stop_a;
        end
        2: begin
          if ($urandom_range(0, 4) != 0) lv_stop_b = !lv_stop_b;
          r.switch_id = stop_b_id;
          r.level = lv_stop_b;
        end
        default: if ($urandom_range(0, 3) != 0) r.switch_id = 8'($urandom_range(0, 15));
      endcase
    end else if (pick < 94) begin
      r.cmd = CMD_TILT;
      r.tilt_active = ($urandom_range(0, 3) != 0);
    end else if (pick < 98) begin
      r.cmd = CMD_POWER_LOST;
      r.power_ok = ($urandom_range(0, 3) == 0);
    end else begin
      r.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_CODES - 1));
    end
    return r;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  // Called right after a rising edge; the write lands on the next one.
  task automatic write_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DRIVE_POWER: drive_pw = val[7:0];
      REG_HOLD_POWER: hold_pw = val[7:0];
      REG_MIN_PULSE_MS: min_on_ms = val;
      REG_MAX_PULSE_MS: max_on_ms = val;
      REG_HOLD_DELAY_MS: hold_after_ms = val;
      REG_DRIVE_SWITCH: drive_sw_id = val[7:0];
      REG_STOP_SWITCH_A: stop_a_id = val[7:0];
      REG_STOP_SWITCH_B: stop_b_id = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits for the channel to drain, then rewrites every register. The upper byte
  // of the narrow registers carries noise that must be dropped.
  task automatic load_config(bit [7:0] dp, bit [7:0] hp, bit [15:0] mn, bit [15:0] mx,
                             bit [15:0] hd, bit [7:0] ds, bit [7:0] sa, bit [7:0] sb);
    wait_idle();
    repeat (4) @(negedge clk);
    @(posedge clk);
    write_reg(REG_DRIVE_POWER, {8'($urandom()), dp});
    write_reg(REG_HOLD_POWER, {8'($urandom()), hp});
    write_reg(REG_MIN_PULSE_MS, mn);
    write_reg(REG_MAX_PULSE_MS, mx);
    write_reg(REG_HOLD_DELAY_MS, hd);
    write_reg(REG_DRIVE_SWITCH, {8'($urandom()), ds});
    write_reg(REG_STOP_SWITCH_A, {8'($urandom()), sa});
    write_reg(REG_STOP_SWITCH_B, {8'($urandom()), sb});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(int n, bit with_idle);
    idling_on = with_idle;
    repeat (n) request_q.push_back(random_request());
  endtask

  task automatic load_random_config();
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 40)), 16'($urandom_range(0, 150)),
                16'($urandom_range(0, 60)), 8'($urandom_range(1, 12)),
                8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)));
  endtask

  initial begin
    cphd_in_t r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: pulse-and-hold timing, stops, tilt, power loss, time wrap.
    load_config(8'd200, 8'd60, 16'd10, 16'd100, 16'd20, 8'd5, 8'd7, 8'd0);
    @(posedge clk);
    // Writes past the last register must leave everything as it is.
    write_reg(REG_UNUSED_NEXT, '1);
    write_reg(REG_UNUSED_TOP, '0);
    cfg_we <= 1'b0;
    @(negedge clk);
    request_q.push_back(req(CMD_HOST, 32'd1000, 8'd0, 1'b1));
    request_q.push_back(req(CMD_TICK, 32'd1025, 8'd0, 1'b0));
    request_q.push_back(req(CMD_HOST, 32'd1030, 8'd0, 1'b0));
    r = req(CMD_HOST, 32'd2000, 8'd0, 1'b1);
    r.power_ok = 1'b0;
    request_q.push_back(r);
    request_q.push_back(req(CMD_HOST, 32'd2000, 8'd0, 1'b1));
    // An off request inside the minimum pulse is deferred to a later tick.
    request_q.push_back(req(CMD_HOST, 32'd2005, 8'd0, 1'b0));
    request_q.push_back(req(CMD_TICK, 32'd2011, 8'd0, 1'b0));
    request_q.push_back(req(CMD_SWITCH, 32'd4000, drive_sw_id, 1'b1));
    request_q.push_back(req(CMD_SWITCH, 32'd4002, stop_a_id, 1'b1));
    request_q.push_back(req(CMD_HOST, 32'd4003, 8'd0, 1'b1));
    request_q.push_back(req(CMD_SWITCH, 32'd4004, stop_a_id, 1'b0));
    // With the stop released, a held drive switch re-fires on the next tick.
    r = req(CMD_TICK, 32'd4005, 8'd0, 1'b0);
    r.drive_switch_closed = 1'b1;
    request_q.push_back(r);
    request_q.push_back(req(CMD_TICK, 32'd4020, 8'd0, 1'b0));
    // Switch number zero must not match an unused stop register.
    request_q.push_back(req(CMD_SWITCH, 32'd4021, 8'd0, 1'b1));
    r = req(CMD_TILT, 32'd4030, 8'd0, 1'b0);
    r.tilt_active = 1'b1;
    request_q.push_back(r);
    r = req(CMD_TICK, 32'd4031, 8'd0, 1'b0);
    r.drive_switch_closed = 1'b1;
    request_q.push_back(r);
    request_q.push_back(req(CMD_TICK, 32'd4032, 8'd0, 1'b0));
    request_q.push_back(req(CMD_TILT, 32'd4033, 8'd0, 1'b0));
    request_q.push_back(req(CMD_HOST, 32'd5000, 8'd0, 1'b1));
    request_q.push_back(req(CMD_POWER_LOST, 32'd5001, 8'd0, 1'b0));
    r = req(CMD_POWER_LOST, 32'd5002, 8'd0, 1'b0);
    r.power_ok = 1'b0;
    request_q.push_back(r);
    for (int c = CMD_UNUSED_FIRST; c < CMD_CODES; c++) begin
      r = '1;
      r.cmd = c[2:0];
      request_q.push_back(r);
    end
    // Elapsed time across the 32-bit wrap: hold drop, then the maximum pulse cut.
    request_q.push_back(req(CMD_HOST, 32'hFFFF_FFF0, 8'd0, 1'b1));
    request_q.push_back(req(CMD_TICK, 32'h0000_0020, 8'd0, 1'b0));
    request_q.push_back(req(CMD_TICK, 32'h0000_0080, 8'd0, 1'b0));

    load_random_config();
    run_random(180, 1'b1);
    load_config(8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    run_random(100, 1'b1);
    load_config(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(140, 1'b1);
    load_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 16'd0, 16'd0,
                16'd7, 8'($urandom_range(1, 12)), 8'd0, 8'($urandom_range(1, 12)));
    run_random(160, 1'b1);
    load_random_config();
    run_random(180, 1'b1);
    load_random_config();
    run_random(200, 1'b0);

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> coil_pulse_hold_driver_unit.f
hw/rtl/cphd_pkg.sv
hw/rtl/coil_pulse_hold_driver_unit.sv
sim/tb_coil_pulse_hold_driver_unit.sv
